[hw/rtl/dbcd_pkg.sv]
// ----------------------------------------------------------------------------
// Debounced button counter package
// Shared types, constants and the seven-segment decoder.
// ----------------------------------------------------------------------------
package dbcd_pkg;

  localparam int NumButtonsDef = 8;
  localparam int FifoDepth     = 2;

  typedef logic [15:0] hist_t;
  typedef logic [9:0]  count_t;
  typedef logic [7:0]  seg_t;
  typedef logic [3:0]  digit_t;

  localparam hist_t  HIST_FORCE  = 16'hE000;
  localparam hist_t  HIST_PRESS  = 16'hF000;
  localparam count_t COUNT_LIMIT = 10'd1023;
  localparam seg_t   SEG_BLANK   = 8'hFF;

  // Display positions in the order the beats leave the block.
  typedef enum logic [2:0] {
    POS_ONES      = 3'd0,
    POS_TENS      = 3'd1,
    POS_COLON     = 3'd2,
    POS_HUNDREDS  = 3'd3,
    POS_THOUSANDS = 3'd4
  } digit_pos_e;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // Active-low segment code of one decimal digit, bit 0 is segment a.
  function automatic seg_t seg_code(input digit_t d);
    seg_t s;
    case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

[hw/rtl/dbcd_front.sv]
// ----------------------------------------------------------------------------
// Debounced button counter front end
// Keeps the per-button histories, detects presses and updates the count.
// ----------------------------------------------------------------------------
module dbcd_front #(
  parameter int NumButtons = dbcd_pkg::NumButtonsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             button_levels_i,
  input  dbcd_pkg::fifo_status_t fifo_status_i,
  output logic                   push_o,
  output dbcd_pkg::count_t       push_count_o
);
  import dbcd_pkg::*;

  hist_t       hist_q [NumButtons];
  hist_t       hist_d [NumButtons];
  count_t      count_q;
  count_t      count_d;
  logic [7:0]  inc;
  logic [10:0] sum;
  logic        accept;

  assign in_stall_o = fifo_status_i.full;
  assign accept     = in_valid_i && !fifo_status_i.full;

  always_comb begin
    inc = '0;
    for (int i = 0; i < NumButtons; i++) begin
      hist_d[i] = {hist_q[i][14:0], button_levels_i[i]} | HIST_FORCE;
      inc[i]    = (hist_d[i] == HIST_PRESS);
    end
  end

  // The sum never exceeds twice the limit, so one subtraction does the modulo.
  always_comb begin
    sum = {1'b0, count_q} + {3'b000, inc};
    if (sum > {1'b0, COUNT_LIMIT}) begin
      sum = sum - {1'b0, COUNT_LIMIT};
    end
    count_d = sum[9:0];
  end

  assign push_o       = accept;
  assign push_count_o = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < NumButtons; i++) begin
        hist_q[i] <= '0;
      end
    end else if (accept) begin
      count_q <= count_d;
      for (int i = 0; i < NumButtons; i++) begin
        hist_q[i] <= hist_d[i];
      end
    end
  end

endmodule

[hw/rtl/dbcd_fifo.sv]
// ----------------------------------------------------------------------------
// Debounced button counter queue
// Short queue of count values between the front end and the display side.
// ----------------------------------------------------------------------------
module dbcd_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  dbcd_pkg::count_t       push_count_i,
  input  logic                   pop_i,
  output dbcd_pkg::count_t       pop_count_o,
  output dbcd_pkg::fifo_status_t status_o
);
  import dbcd_pkg::*;

  localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntW = $clog2(FifoDepth + 1);

  count_t            mem_q [FifoDepth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   fill_q;
  logic              do_push;
  logic              do_pop;

  assign status_o.full  = (fill_q == CntW'(FifoDepth));
  assign status_o.empty = (fill_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_count_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/dbcd_back.sv]
// ----------------------------------------------------------------------------
// Debounced button counter display back end
// Splits the count into decimal digits and sends five display beats.
// ----------------------------------------------------------------------------
module dbcd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dbcd_pkg::fifo_status_t fifo_status_i,
  input  dbcd_pkg::count_t       fifo_count_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             segments_o,
  output logic [2:0]             digit_select_o,
  output logic [9:0]             count_value_o,
  output logic                   last_o
);
  import dbcd_pkg::*;

  // Multiplying by this and dropping 19 bits divides by ten for any 16-bit value.
  localparam logic [15:0] RecipTen = 16'd52429;

  logic          s1_v_q, s2_v_q, s3_v_q;
  logic          s1_free, s2_free, s3_free;
  count_t        s1_cnt_q, s2_cnt_q, s3_cnt_q;
  logic [6:0]    s1_q1_q, s2_q1_q;
  digit_t        s2_d0_q, s2_q2_q;
  seg_t [3:0]    s3_seg_q;
  digit_pos_e    beat_q, beat_d;

  logic [25:0]   prod1;
  logic [22:0]   prod2;
  logic [9:0]    d0_full;
  logic [6:0]    d1_full;
  digit_t        d1, d2;
  logic          d3;
  logic          last_beat;

  assign last_beat = (beat_q == POS_THOUSANDS);
  assign s3_free   = !s3_v_q || (!out_stall_i && last_beat);
  assign s2_free   = !s2_v_q || s3_free;
  assign s1_free   = !s1_v_q || s2_free;
  assign pop_o     = !fifo_status_i.empty && s1_free;

  // Stage one: count divided by ten.
  assign prod1 = {16'd0, fifo_count_i} * {10'd0, RecipTen};

  // Stage two: ones digit and the count divided by a hundred.
  assign d0_full = s1_cnt_q - ({3'd0, s1_q1_q} * 10'd10);
  assign prod2   = {16'd0, s1_q1_q} * {7'd0, RecipTen};

  // Stage three: tens, hundreds and thousands digits.
  assign d1_full = s2_q1_q - ({3'd0, s2_q2_q} * 7'd10);
  assign d1      = d1_full[3:0];
  assign d3      = (s2_q2_q >= 4'd10);
  assign d2      = d3 ? (s2_q2_q - 4'd10) : s2_q2_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_cnt_q <= fifo_count_i;
      s1_q1_q  <= prod1[25:19];
    end
    if (s1_v_q && s2_free) begin
      s2_cnt_q <= s1_cnt_q;
      s2_q1_q  <= s1_q1_q;
      s2_d0_q  <= d0_full[3:0];
      s2_q2_q  <= prod2[22:19];
    end
    if (s2_v_q && s3_free) begin
      s3_cnt_q    <= s2_cnt_q;
      s3_seg_q[0] <= seg_code(s2_d0_q);
      s3_seg_q[1] <= (s2_cnt_q >= 10'd10)   ? seg_code(d1) : SEG_BLANK;
      s3_seg_q[2] <= (s2_cnt_q >= 10'd100)  ? seg_code(d2) : SEG_BLANK;
      s3_seg_q[3] <= (s2_cnt_q >= 10'd1000) ? seg_code({3'd0, d3}) : SEG_BLANK;
    end
  end

  always_comb begin
    case (beat_q)
      POS_ONES:      beat_d = POS_TENS;
      POS_TENS:      beat_d = POS_COLON;
      POS_COLON:     beat_d = POS_HUNDREDS;
      POS_HUNDREDS:  beat_d = POS_THOUSANDS;
      POS_THOUSANDS: beat_d = POS_ONES;
      default:       beat_d = POS_ONES;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      beat_q <= POS_ONES;
    end else begin
      if (s1_free) begin
        s1_v_q <= pop_o;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_free) begin
        s3_v_q <= s2_v_q;
      end
      if (s3_v_q && !out_stall_i) begin
        beat_q <= beat_d;
      end
    end
  end

  always_comb begin
    case (beat_q)
      POS_ONES:      segments_o = s3_seg_q[0];
      POS_TENS:      segments_o = s3_seg_q[1];
      POS_COLON:     segments_o = SEG_BLANK;
      POS_HUNDREDS:  segments_o = s3_seg_q[2];
      POS_THOUSANDS: segments_o = s3_seg_q[3];
      default:       segments_o = SEG_BLANK;
    endcase
  end

  assign out_valid_o    = s3_v_q;
  assign digit_select_o = beat_q;
  assign count_value_o  = s3_cnt_q;
  assign last_o         = last_beat;

endmodule

[hw/rtl/debounced_button_counter_display.sv]
// A tick's count goes through the queue and the display stage registers to its
// first beat; the other four beats follow one per cycle unless out_stall_i holds
// them, and a tick's beats start once the last beat of the one before is taken;
// the front end takes ticks back to back until its two-entry queue is full.
// Reset clears the button histories, the running count and all valid flags.
// ----------------------------------------------------------------------------
// Debounced button counter with seven-segment display
// Counts debounced button presses and sends the count as display digit beats.
// ----------------------------------------------------------------------------
module debounced_button_counter_display #(
  parameter int NumButtons = dbcd_pkg::NumButtonsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] button_levels_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] segments_o,
  output logic [2:0] digit_select_o,
  output logic [9:0] count_value_o,
  output logic       last_o
);
  import dbcd_pkg::*;

  fifo_status_t fifo_status;
  logic         push;
  logic         pop;
  count_t       push_count;
  count_t       pop_count;

  dbcd_front #(
    .NumButtons(NumButtons)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .button_levels_i(button_levels_i),
    .fifo_status_i  (fifo_status),
    .push_o         (push),
    .push_count_o   (push_count)
  );

  dbcd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_count_i(push_count),
    .pop_i       (pop),
    .pop_count_o (pop_count),
    .status_o    (fifo_status)
  );

  dbcd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_status_i (fifo_status),
    .fifo_count_i  (pop_count),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .segments_o    (segments_o),
    .digit_select_o(digit_select_o),
    .count_value_o (count_value_o),
    .last_o        (last_o)
  );

endmodule

[dv/tb_debounced_button_counter_display.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debounced button counter display testbench
// Drives scan ticks of raw button levels into the block, predicts the
// debounced count and its five display beats per tick, and checks every
// output beat in order under random idling and stalling on both sides.
// ----------------------------------------------------------------------------
module tb_debounced_button_counter_display;
  import dbcd_pkg::*;

  localparam int NumBtn      = 8;
  localparam int RandomTicks = 260;
  localparam int LongHoldLen = 400;

  // Active-low segment code of each decimal digit, bit 0 is segment a.
  localparam seg_t DigitSeg [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  typedef struct packed {
    seg_t       segments;
    digit_pos_e pos;
    count_t     count;
    logic       last;
  } digit_beat_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] button_levels = 8'hFF;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] segments;
  logic [2:0] digit_select;
  logic [9:0] count_value;
  logic       last;

  logic       rand_stall   = 1'b0;
  logic       long_hold    = 1'b0;

  logic [7:0]  tick_q [$];
  digit_beat_t digit_q [$];

  // Own copy of the block's state.
  hist_t  btn_history [NumBtn];
  count_t press_count;

  int errors     = 0;
  int beats_seen = 0;

  int send_wait  = 0;
  int send_burst = 0;
  logic send_idle = 1'b0;
  int recv_wait  = 0;
  int recv_burst = 0;
  logic recv_idle = 1'b0;
  int hold_left  = 0;
  logic hold_done = 1'b0;

  assign out_stall = rand_stall | long_hold;

  debounced_button_counter_display DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .button_levels_i(button_levels),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .segments_o     (segments),
    .digit_select_o (digit_select),
    .count_value_o  (count_value),
    .last_o         (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic reset_count_model();
    for (int b = 0; b < NumBtn; b++) begin
      btn_history[b] = '0;
    end
    press_count = '0;
  endtask

  // Advance every button history by one tick, update the count and queue the
  // five display beats the tick should produce.
  task automatic predict_tick(input logic [7:0] levels);
    int unsigned sum;
    hist_t       h;
    seg_t        segs [5];
    digit_beat_t beat;
    sum = 32'(press_count);
    for (int b = 0; b < NumBtn; b++) begin
      h = {btn_history[b][14:0], levels[b]} | HIST_FORCE;
      btn_history[b] = h;
      if (h == HIST_PRESS) begin
        sum += (1 << b);
      end
    end
    if (sum > 1023) begin
      sum = sum % 1023;
    end
    press_count = sum[9:0];
    segs[0] = DigitSeg[4'(sum % 10)];
    segs[1] = (sum >= 10) ? DigitSeg[4'((sum / 10) % 10)] : SEG_BLANK;
    segs[2] = SEG_BLANK;
    segs[3] = (sum >= 100) ? DigitSeg[4'((sum / 100) % 10)] : SEG_BLANK;
    segs[4] = (sum >= 1000) ? DigitSeg[4'((sum / 1000) % 10)] : SEG_BLANK;
    for (int k = 0; k < 5; k++) begin
      beat.segments = segs[k];
      beat.pos      = digit_pos_e'(k);
      beat.count    = press_count;
      beat.last     = (k == 4);
      digit_q.push_back(beat);
    end
  endtask

  // Sender: presents queued ticks with a random gap after each accepted tick.
  always @(posedge clk or negedge rst_n) begin : tick_driver
    logic nxt_valid;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        predict_tick(button_levels);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
        end else if (tick_q.size() != 0) begin
          button_levels <= tick_q.pop_front();
          nxt_valid = 1'b1;
          if (send_burst == 0) begin
            send_idle  <= ~send_idle;
            send_burst <= $urandom_range(8, 40);
          end else begin
            send_burst <= send_burst - 1;
          end
          // Keep offering back to back while the receiver is held off.
          send_wait <= (send_idle && !long_hold) ? $urandom_range(0, 19) : 0;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Receiver: checks each accepted beat against the oldest prediction.
  always @(posedge clk or negedge rst_n) begin : beat_monitor
    digit_beat_t exp_b;
    int          n;
    if (!rst_n) begin
      rand_stall <= 1'b0;
      recv_wait  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (digit_q.size() == 0) begin
          $display("%0t: unexpected beat segments %h pos %0d count %0d last %b",
                   $time, segments, digit_select, count_value, last);
          errors++;
        end else begin
          exp_b = digit_q.pop_front();
          if (segments !== exp_b.segments) begin
            $display("%0t: segments expected %h actual %h", $time,
                     exp_b.segments, segments);
            errors++;
          end
          if (digit_select !== exp_b.pos) begin
            $display("%0t: digit_select expected %0d actual %0d", $time,
                     exp_b.pos, digit_select);
            errors++;
          end
          if (count_value !== exp_b.count) begin
            $display("%0t: count_value expected %0d actual %0d", $time,
                     exp_b.count, count_value);
            errors++;
          end
          if (last !== exp_b.last) begin
            $display("%0t: last expected %b actual %b", $time, exp_b.last, last);
            errors++;
          end
        end
        beats_seen <= beats_seen + 1;
        if (recv_burst == 0) begin
          recv_idle  <= ~recv_idle;
          recv_burst <= $urandom_range(10, 60);
        end else begin
          recv_burst <= recv_burst - 1;
        end
        n = recv_idle ? $urandom_range(0, 19) : 0;
        recv_wait  <= n;
        rand_stall <= (n != 0);
      end else if (recv_wait != 0) begin
        recv_wait  <= recv_wait - 1;
        rand_stall <= (recv_wait > 1);
      end
    end
  end

  // One long hold-off of the output so the block fills and stalls its input.
  always @(posedge clk or negedge rst_n) begin : hold_off_ctl
    if (!rst_n) begin
      long_hold <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && beats_seen >= 150) begin
      long_hold <= 1'b1;
      hold_left <= LongHoldLen;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      long_hold <= (hold_left > 1);
    end
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int   run_left [NumBtn];
    logic pressed  [NumBtn];
    logic [7:0] lv;

    reset_count_model();

    // Directed: all released, then all held for twelve ticks so every button
    // registers at once, then mixed and extreme patterns.
    tick_q.push_back(8'hFF);
    repeat (12) tick_q.push_back(8'h00);
    tick_q.push_back(8'hAA);
    tick_q.push_back(8'h55);
    tick_q.push_back(8'h01);
    tick_q.push_back(8'h80);
    tick_q.push_back(8'hFF);
    tick_q.push_back(8'h00);
    tick_q.push_back(8'hFE);
    tick_q.push_back(8'h7F);

    // Random: mostly clean press and release runs per button, some noise.
    for (int b = 0; b < NumBtn; b++) begin
      pressed[b]  = 1'b0;
      run_left[b] = $urandom_range(1, 4);
    end
    for (int i = 0; i < RandomTicks; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        lv = 8'($urandom_range(0, 255));
      end else begin
        for (int b = 0; b < NumBtn; b++) begin
          if (run_left[b] == 0) begin
            pressed[b]  = ~pressed[b];
            run_left[b] = pressed[b] ?
                          (($urandom_range(0, 3) == 0) ? $urandom_range(1, 11)
                                                       : $urandom_range(12, 18))
                          : $urandom_range(1, 3);
          end
          run_left[b]--;
          lv[b] = ~pressed[b];
        end
      end
      tick_q.push_back(lv);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Sample away from the rising edge so the driver's updates have settled.
    while (tick_q.size() != 0 || in_valid || digit_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
